// ===== rtl/core/icss_pkg.sv =====
// Shared types and constants for the impulse capture block.
// No dependencies; used by icss_ctrl and the top level, not by icss_store.
`default_nettype none

package icss_pkg;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_CAPTURING = 2'd1,
    PH_COMPLETE  = 2'd2
  } phase_t;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] REG_STOP_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MAX_FRAMES     = 2'd1;
  localparam logic [1:0] REG_QUIET_REQUIRED = 2'd2;

  localparam int THR_W   = 23;
  localparam int MAXF_W  = 15;
  localparam int QUIET_W = 16;
  localparam int CFG_W   = 23;

  localparam logic [THR_W-1:0]   THR_RESET   = 23'd8389;
  localparam logic [MAXF_W-1:0]  MAXF_RESET  = 15'd16384;
  localparam logic [QUIET_W-1:0] QUIET_RESET = 16'd4800;
  localparam logic [QUIET_W-1:0] QUIET_MAX   = 16'hFFFF;

  typedef struct packed {
    phase_t phase;
    logic   thr_stop;
    logic   done;
    logic   rd_ok;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/icss_store.sv =====
// Left and right sample stores: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module icss_store #(
  parameter int STORE_DEPTH = 16384,
  parameter int SAMPLE_BITS = 24,
  parameter int IDX_W       = 14
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [IDX_W-1:0]       wr_addr,
  input  wire logic [SAMPLE_BITS-1:0] wr_left,
  input  wire logic [SAMPLE_BITS-1:0] wr_right,
  input  wire logic                   rd_en,
  input  wire logic [IDX_W-1:0]       rd_addr,
  output logic      [SAMPLE_BITS-1:0] rd_left,
  output logic      [SAMPLE_BITS-1:0] rd_right
);

  logic [SAMPLE_BITS-1:0] left_mem  [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] right_mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_addr]  <= wr_left;
      right_mem[wr_addr] <= wr_right;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_left  <= left_mem[rd_addr];
      rd_right <= right_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/icss_ctrl.sv =====
// Capture control: config registers, phase, frame and quiet counters.
// Depends on icss_pkg.
`default_nettype none

module icss_ctrl #(
  parameter int STORE_DEPTH = 16384,
  parameter int SAMPLE_BITS = 24,
  parameter int IDX_W       = 14,
  parameter int CNT_W       = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [icss_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic                        acc,
  input  wire logic [1:0]                  cmd,
  input  wire logic [SAMPLE_BITS-1:0]      left_sample,
  input  wire logic [SAMPLE_BITS-1:0]      right_sample,
  input  wire logic [IDX_W-1:0]            read_index,
  output icss_pkg::status_t                status,
  output logic      [CNT_W-1:0]            frames,
  output logic                             wr_en,
  output logic      [IDX_W-1:0]            wr_addr
);

  localparam int MAG_W = SAMPLE_BITS - 1;
  localparam int CMP_W = (MAG_W > icss_pkg::THR_W) ? MAG_W : icss_pkg::THR_W;
  localparam int LIM_W = (CNT_W > icss_pkg::MAXF_W) ? CNT_W : icss_pkg::MAXF_W;
  localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {MAG_W{1'b0}}};
  localparam logic [MAG_W-1:0]       MAG_MAX  = {MAG_W{1'b1}};

  function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_BITS-1:0] v);
    logic [SAMPLE_BITS-1:0] neg;
    neg = -v;
    if (v == MOST_NEG) begin
      return MAG_MAX;
    end else if (v[SAMPLE_BITS-1]) begin
      return neg[MAG_W-1:0];
    end else begin
      return v[MAG_W-1:0];
    end
  endfunction

  logic [icss_pkg::THR_W-1:0]   thr_r;
  logic [icss_pkg::MAXF_W-1:0]  maxf_r;
  logic [icss_pkg::QUIET_W-1:0] qreq_r;

  icss_pkg::phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]             frame_cnt_r, frame_cnt_nxt;
  logic [icss_pkg::QUIET_W-1:0] quiet_r, quiet_nxt;
  logic                         seen_r, seen_nxt;
  logic                         tstop_r, tstop_nxt;
  logic                         done_r, done_nxt;
  logic                         rd_ok_r, rd_ok_nxt;

  logic [LIM_W-1:0]  limit;
  logic [LIM_W-1:0]  cnt_ext;
  logic [LIM_W-1:0]  cnt_inc;
  logic [MAG_W-1:0]  mag_l, mag_r, peak;
  logic              loud;
  logic              take_frame;

  always_comb begin
    if (LIM_W'(maxf_r) > LIM_W'(STORE_DEPTH)) begin
      limit = LIM_W'(STORE_DEPTH);
    end else begin
      limit = LIM_W'(maxf_r);
    end
    cnt_ext = LIM_W'(frame_cnt_r);
    cnt_inc = cnt_ext + LIM_W'(1);
    mag_l   = magnitude(left_sample);
    mag_r   = magnitude(right_sample);
    peak    = (mag_l > mag_r) ? mag_l : mag_r;
    loud    = CMP_W'(peak) > CMP_W'(thr_r);
    take_frame = (cmd == icss_pkg::CMD_FRAME) && (phase_r == icss_pkg::PH_CAPTURING) &&
                 (cnt_ext < limit);
  end

  always_comb begin
    phase_nxt     = phase_r;
    frame_cnt_nxt = frame_cnt_r;
    quiet_nxt     = quiet_r;
    seen_nxt      = seen_r;
    tstop_nxt     = tstop_r;
    done_nxt      = 1'b0;
    rd_ok_nxt     = 1'b0;
    unique case (cmd)
      icss_pkg::CMD_START: begin
        frame_cnt_nxt = '0;
        quiet_nxt     = '0;
        seen_nxt      = 1'b0;
        tstop_nxt     = 1'b0;
        if (limit == '0) begin
          phase_nxt = icss_pkg::PH_COMPLETE;
          done_nxt  = 1'b1;
        end else begin
          phase_nxt = icss_pkg::PH_CAPTURING;
        end
      end
      icss_pkg::CMD_FRAME: begin
        if (take_frame) begin
          if (loud) begin
            seen_nxt  = 1'b1;
            quiet_nxt = '0;
          end else if (seen_r && quiet_r != icss_pkg::QUIET_MAX) begin
            quiet_nxt = quiet_r + icss_pkg::QUIET_W'(1);
          end
          frame_cnt_nxt = frame_cnt_r + CNT_W'(1);
          if (seen_nxt && quiet_nxt >= qreq_r) begin
            tstop_nxt = 1'b1;
            phase_nxt = icss_pkg::PH_COMPLETE;
            done_nxt  = 1'b1;
          end else if (cnt_inc >= limit) begin
            tstop_nxt = 1'b0;
            phase_nxt = icss_pkg::PH_COMPLETE;
            done_nxt  = 1'b1;
          end
        end
      end
      icss_pkg::CMD_READ: begin
        rd_ok_nxt = CNT_W'(read_index) < frame_cnt_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= icss_pkg::THR_RESET;
      maxf_r      <= icss_pkg::MAXF_RESET;
      qreq_r      <= icss_pkg::QUIET_RESET;
      phase_r     <= icss_pkg::PH_IDLE;
      frame_cnt_r <= '0;
      quiet_r     <= '0;
      seen_r      <= 1'b0;
      tstop_r     <= 1'b0;
      done_r      <= 1'b0;
      rd_ok_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          icss_pkg::REG_STOP_THRESHOLD: thr_r  <= cfg_wdata[icss_pkg::THR_W-1:0];
          icss_pkg::REG_MAX_FRAMES:     maxf_r <= cfg_wdata[icss_pkg::MAXF_W-1:0];
          icss_pkg::REG_QUIET_REQUIRED: qreq_r <= cfg_wdata[icss_pkg::QUIET_W-1:0];
          default: begin
          end
        endcase
      end
      if (acc) begin
        phase_r     <= phase_nxt;
        frame_cnt_r <= frame_cnt_nxt;
        quiet_r     <= quiet_nxt;
        seen_r      <= seen_nxt;
        tstop_r     <= tstop_nxt;
        done_r      <= done_nxt;
        rd_ok_r     <= rd_ok_nxt;
      end
    end
  end

  assign status.phase    = phase_r;
  assign status.thr_stop = tstop_r;
  assign status.done     = done_r;
  assign status.rd_ok    = rd_ok_r;
  assign frames          = frame_cnt_r;
  assign wr_en           = acc && take_frame;
  assign wr_addr         = frame_cnt_r[IDX_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/impulse_capture_with_silence_stop.sv =====
// Top level of the stereo impulse capture block with stop on trailing silence.
// Depends on icss_pkg, icss_ctrl and icss_store.
// Throughput is one word per cycle unless out_stall holds the pipeline; an
// accepted word passes a stage for the counter update and the store's registered
// read port, then the output register. The stores have no reset and need no
// clearing pass: reads are bounded by the frame count of the current capture.
`default_nettype none

module impulse_capture_with_silence_stop #(
  parameter int STORE_DEPTH = 16384,
  parameter int SAMPLE_BITS = 24,
  localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
  localparam int CNT_W = $clog2(STORE_DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [icss_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_cmd,
  input  wire logic [SAMPLE_BITS-1:0]     in_left_sample,
  input  wire logic [SAMPLE_BITS-1:0]     in_right_sample,
  input  wire logic [IDX_W-1:0]           in_read_index,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [1:0]                 out_phase,
  output logic      [CNT_W-1:0]           out_frames_captured,
  output logic                            out_stopped_by_threshold,
  output logic                            out_just_completed,
  output logic      [SAMPLE_BITS-1:0]     out_read_left,
  output logic      [SAMPLE_BITS-1:0]     out_read_right,
  output logic                            out_read_ok
);

  icss_pkg::status_t      status;
  logic [CNT_W-1:0]       frames;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [SAMPLE_BITS-1:0] rd_left, rd_right;

  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic acc;

  logic [1:0]             phase_r;
  logic [CNT_W-1:0]       frames_r;
  logic                   tstop_r;
  logic                   done_r;
  logic [SAMPLE_BITS-1:0] rd_left_r, rd_right_r;
  logic                   rd_ok_r;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign acc      = in_valid && !in_stall;

  icss_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .acc          (acc),
    .cmd          (in_cmd),
    .left_sample  (in_left_sample),
    .right_sample (in_right_sample),
    .read_index   (in_read_index),
    .status       (status),
    .frames       (frames),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr)
  );

  icss_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_left  (in_left_sample),
    .wr_right (in_right_sample),
    .rd_en    (acc && (in_cmd == icss_pkg::CMD_READ)),
    .rd_addr  (in_read_index),
    .rd_left  (rd_left),
    .rd_right (rd_right)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      phase_r    <= status.phase;
      frames_r   <= frames;
      tstop_r    <= status.thr_stop;
      done_r     <= status.done;
      rd_ok_r    <= status.rd_ok;
      rd_left_r  <= status.rd_ok ? rd_left : '0;
      rd_right_r <= status.rd_ok ? rd_right : '0;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_phase                = phase_r;
  assign out_frames_captured      = frames_r;
  assign out_stopped_by_threshold = tstop_r;
  assign out_just_completed       = done_r;
  assign out_read_left            = rd_left_r;
  assign out_read_right           = rd_right_r;
  assign out_read_ok              = rd_ok_r;

endmodule

`default_nettype wire
